// ----- rtl/alid_pkg.sv -----
// Shared types and constants for the array list insert/delete block.
package alid_pkg;

  localparam int DATA_W = 32;
  localparam int POS_W  = 6;
  localparam int CNT_W  = 6;
  localparam int CAP_W  = 6;

  localparam logic [CAP_W-1:0] CAP_RESET = 6'd32;

  // request codes carried on the input tuser
  localparam logic [1:0] REQ_READ   = 2'd0;
  localparam logic [1:0] REQ_INSERT = 2'd1;
  localparam logic [1:0] REQ_DELETE = 2'd2;

  // position -1: insert at the front
  localparam logic [POS_W-1:0] POS_FRONT = 6'b111111;

  typedef enum logic [1:0] {
    CMD_HOLD   = 2'd0,
    CMD_INSERT = 2'd1,
    CMD_DELETE = 2'd2
  } cell_cmd_t;

  // broadcast to every cell of the row
  typedef struct packed {
    cell_cmd_t          cmd;
    logic [POS_W-1:0]   at;
    logic [DATA_W-1:0]  value;
  } cell_ctl_t;

  // request outcome handed from the controller to the output stage
  typedef struct packed {
    logic             ok;
    logic             rd_en;
    logic [CNT_W-1:0] count;
  } req_res_t;

endpackage

// ----- rtl/alid_cell.sv -----
// One list entry: holds its value and shifts toward a neighbor on insert or delete.
module alid_cell #(
  parameter int IDX = 0
) (
  input  logic                           clk,
  input  alid_pkg::cell_ctl_t            ctl,
  input  logic [alid_pkg::DATA_W-1:0]    left_in,
  input  logic [alid_pkg::DATA_W-1:0]    right_in,
  output logic [alid_pkg::DATA_W-1:0]    data,
  output logic [alid_pkg::DATA_W-1:0]    rd_out
);

  logic [alid_pkg::DATA_W-1:0] data_next;
  int                          at_i;

  assign at_i = int'(ctl.at);

  always_comb begin
    data_next = data;
    unique case (ctl.cmd)
      alid_pkg::CMD_HOLD: begin
        data_next = data;
      end
      alid_pkg::CMD_INSERT: begin
        if (IDX > at_i) begin
          data_next = left_in;
        end else if (IDX == at_i) begin
          data_next = ctl.value;
        end
      end
      alid_pkg::CMD_DELETE: begin
        if (IDX >= at_i) begin
          data_next = right_in;
        end
      end
      default: begin
        data_next = data;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    data <= data_next;
  end

  // drive own value onto the read bus only when addressed
  assign rd_out = (IDX == at_i) ? data : '0;

endmodule

// ----- rtl/alid_ctrl.sv -----
// Request checker, entry counter and capacity register.
module alid_ctrl #(
  parameter int DEPTH = 32
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          cfg_wen,
  input  logic [alid_pkg::CAP_W-1:0]    cfg_wdata,
  input  logic                          fire,
  input  logic [1:0]                    req_type,
  input  logic [alid_pkg::POS_W-1:0]    position,
  input  logic [alid_pkg::DATA_W-1:0]   value,
  output alid_pkg::cell_ctl_t           ctl,
  output alid_pkg::req_res_t            res
);

  localparam int UW = $clog2(DEPTH + 1);

  logic [UW-1:0]                 used;
  logic [UW-1:0]                 used_next;
  logic [alid_pkg::CAP_W-1:0]    capacity;
  int                            used_i;
  int                            cap_i;
  logic                          in_range;
  logic                          front;
  logic                          ok;
  logic                          rd_en;
  alid_pkg::cell_cmd_t           cmd;

  assign used_i   = int'(used);
  assign cap_i    = (int'(capacity) > DEPTH) ? DEPTH : int'(capacity);
  assign in_range = !position[alid_pkg::POS_W-1] &&
                    (int'(position[alid_pkg::POS_W-2:0]) < used_i);
  assign front    = (position == alid_pkg::POS_FRONT);

  always_comb begin
    ok        = 1'b0;
    rd_en     = 1'b0;
    cmd       = alid_pkg::CMD_HOLD;
    used_next = used;
    unique case (req_type)
      alid_pkg::REQ_READ: begin
        ok    = in_range;
        rd_en = in_range;
      end
      alid_pkg::REQ_INSERT: begin
        if ((front || in_range) && (used_i < cap_i)) begin
          ok        = 1'b1;
          cmd       = alid_pkg::CMD_INSERT;
          used_next = used + UW'(1);
        end
      end
      alid_pkg::REQ_DELETE: begin
        if (in_range) begin
          ok        = 1'b1;
          cmd       = alid_pkg::CMD_DELETE;
          used_next = used - UW'(1);
        end
      end
      default: begin
        ok = 1'b0;
      end
    endcase
  end

  // insert lands one past the given position; -1 wraps to the front
  assign ctl.cmd   = fire ? cmd : alid_pkg::CMD_HOLD;
  assign ctl.at    = (req_type == alid_pkg::REQ_INSERT) ?
                     alid_pkg::POS_W'(position + alid_pkg::POS_W'(1)) : position;
  assign ctl.value = value;

  assign res.ok    = ok;
  assign res.rd_en = rd_en;
  assign res.count = alid_pkg::CNT_W'(used_next);

  always_ff @(posedge clk) begin
    if (rst) begin
      used     <= '0;
      capacity <= alid_pkg::CAP_RESET;
    end else begin
      if (fire) begin
        used <= used_next;
      end
      if (cfg_wen) begin
        capacity <= cfg_wdata;
      end
    end
  end

  a_used_bound: assert property (@(posedge clk) disable iff (rst)
    int'(used) <= DEPTH)
    else $error("entry count exceeds store depth");

  a_insert_grows: assert property (@(posedge clk) disable iff (rst)
    !rst && fire && ok && (cmd == alid_pkg::CMD_INSERT) |=> used == $past(used) + UW'(1))
    else $error("accepted insert did not grow the list");

  a_delete_shrinks: assert property (@(posedge clk) disable iff (rst)
    !rst && fire && ok && (cmd == alid_pkg::CMD_DELETE) |=> used == $past(used) - UW'(1))
    else $error("accepted delete did not shrink the list");

  a_reject_keeps: assert property (@(posedge clk) disable iff (rst)
    !rst && (!fire || !ok || rd_en) |=> $stable(used))
    else $error("count moved without a successful insert or delete");

endmodule

// ----- rtl/array_list_insert_delete.sv -----
// Top level of the array list: request channel, row of entry cells, result register.
//
// Usage:
//   Requests arrive on the s_axis channel. tuser carries the request kind
//   (read, insert after position, delete at position); tdata carries the
//   position and the value to insert. Each request produces exactly one
//   result beat on m_axis: tuser[0] is the success flag, tdata holds the
//   value read (zero unless a read succeeded) and the entry count after the
//   request.
//   The result is registered: the edge that accepts a request loads its
//   result. Throughput is one request per cycle while results drain; the
//   cell row shifts every entry at once on insert or delete, and the entry
//   counter in the controller decides each request in the cycle it is accepted.
//   A stalled receiver holds the result register; s_axis_tready stays high
//   while the register is empty or being drained in the same cycle.
//   Reset empties the list and sets capacity to 32. Entry storage is not
//   cleared; entries beyond the count are never visible. Write capacity on
//   cfg_wen/cfg_wdata only while no request is in flight.
module array_list_insert_delete #(
  parameter int DEPTH = 32
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_wen,
  input  logic [5:0]  cfg_wdata,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [39:0] s_axis_tdata,   // [5:0] position, [37:6] value, [39:38] zero
  input  logic [1:0]  s_axis_tuser,   // [1:0] req_type
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [39:0] m_axis_tdata,   // [31:0] read_value, [37:32] count, [39:38] zero
  output logic [0:0]  m_axis_tuser    // [0] ok
);

  localparam int DW = alid_pkg::DATA_W;

  logic                 fire;
  alid_pkg::cell_ctl_t  ctl;
  alid_pkg::req_res_t   res;
  logic [DW-1:0]        cell_data [DEPTH];
  logic [DW-1:0]        cell_rd   [DEPTH];
  logic [DW-1:0]        rd_bus;

  // accept whenever the result register is free or draining
  assign s_axis_tready = !m_axis_tvalid || m_axis_tready;
  assign fire          = s_axis_tvalid && s_axis_tready;

  alid_ctrl #(
    .DEPTH (DEPTH)
  ) u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .cfg_wen   (cfg_wen),
    .cfg_wdata (cfg_wdata),
    .fire      (fire),
    .req_type  (s_axis_tuser),
    .position  (s_axis_tdata[5:0]),
    .value     (s_axis_tdata[37:6]),
    .ctl       (ctl),
    .res       (res)
  );

  // Row of cells: each takes its left neighbor on insert, its right on delete.
  for (genvar g = 0; g < DEPTH; g++) begin : g_cell
    logic [DW-1:0] left_in;
    logic [DW-1:0] right_in;

    if (g == 0) begin : g_first
      assign left_in = '0;
    end else begin : g_mid_l
      assign left_in = cell_data[g-1];
    end

    if (g == DEPTH - 1) begin : g_last
      assign right_in = '0;
    end else begin : g_mid_r
      assign right_in = cell_data[g+1];
    end

    alid_cell #(
      .IDX (g)
    ) u_cell (
      .clk      (clk),
      .ctl      (ctl),
      .left_in  (left_in),
      .right_in (right_in),
      .data     (cell_data[g]),
      .rd_out   (cell_rd[g])
    );
  end

  // Only the addressed cell drives a nonzero word, so OR the row together.
  always_comb begin
    rd_bus = '0;
    for (int i = 0; i < DEPTH; i++) begin
      rd_bus = rd_bus | cell_rd[i];
    end
  end

  // Result register: load on accept, drop valid once the receiver takes it.
  always_ff @(posedge clk) begin
    if (rst) begin
      m_axis_tvalid <= 1'b0;
    end else if (fire) begin
      m_axis_tvalid <= 1'b1;
    end else if (m_axis_tready) begin
      m_axis_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (fire) begin
      m_axis_tdata <= {2'b00, res.count, (res.rd_en ? rd_bus : '0)};
      m_axis_tuser <= res.ok;
    end
  end

endmodule

// ----- tb/sv/array_list_insert_delete_tb.sv -----
// Self-checking testbench for the array list insert/delete block.
module array_list_insert_delete_tb;

  // request kind the block must ignore
  localparam logic [1:0] REQ_UNKNOWN = 2'd3;
  localparam int LIST_DEPTH = 32;
  // receiver hold-off used to back the block up into its input
  localparam int HOLD_CYCLES = 60;

  typedef struct packed {
    logic                        ok;
    logic [alid_pkg::DATA_W-1:0] read_value;
    logic [alid_pkg::CNT_W-1:0]  count;
  } list_outcome_t;

  // Shadow copy of the list: applies each accepted request in order and
  // queues the outcome the block must return for it.
  class array_list_tracker;
    logic [alid_pkg::DATA_W-1:0] slots [LIST_DEPTH];
    int fill;
    int cap_reg;
    list_outcome_t pending_outcomes [$];
    int mismatches;
    int outcomes_checked;
    int seen_by_kind [4];
    int done_by_kind [4];
    int peak_fill;
    int full_rejects;

    function new();
      fill = 0;
      cap_reg = 32;
      mismatches = 0;
      outcomes_checked = 0;
      peak_fill = 0;
      full_rejects = 0;
      foreach (seen_by_kind[k]) begin
        seen_by_kind[k] = 0;
        done_by_kind[k] = 0;
      end
    endfunction

    function void set_capacity(logic [alid_pkg::CAP_W-1:0] cap);
      cap_reg = int'(cap);
    endfunction

    function void apply_request(logic [1:0] kind, logic [alid_pkg::POS_W-1:0] pos_bits,
                                logic [alid_pkg::DATA_W-1:0] value);
      int p;
      int limit;
      list_outcome_t res;
      p = int'($signed(pos_bits));
      limit = (cap_reg > LIST_DEPTH) ? LIST_DEPTH : cap_reg;
      res = '0;
      seen_by_kind[kind]++;
      case (kind)
        alid_pkg::REQ_READ: begin
          if (p >= 0 && p < fill) begin
            res.ok = 1'b1;
            res.read_value = slots[p];
          end
        end
        alid_pkg::REQ_INSERT: begin
          // the new entry lands right after p; everything behind it moves up
          if (p >= -1 && p <= fill - 1 && fill < limit) begin
            for (int i = fill; i > p + 1; i--) slots[i] = slots[i-1];
            slots[p+1] = value;
            fill++;
            res.ok = 1'b1;
          end else if (p >= -1 && p <= fill - 1) begin
            full_rejects++;
          end
        end
        alid_pkg::REQ_DELETE: begin
          if (p >= 0 && p < fill) begin
            for (int i = p + 1; i < fill; i++) slots[i-1] = slots[i];
            fill--;
            res.ok = 1'b1;
          end
        end
        default: ;
      endcase
      res.count = alid_pkg::CNT_W'(fill);
      if (res.ok) done_by_kind[kind]++;
      if (fill > peak_fill) peak_fill = fill;
      pending_outcomes.push_back(res);
    endfunction

    task flag_mismatch(string what);
      mismatches++;
      $display("[%0t] MISMATCH %s", $time, what);
    endtask

    task check_outcome(logic ok, logic [alid_pkg::DATA_W-1:0] rd,
                       logic [alid_pkg::CNT_W-1:0] cnt);
      list_outcome_t want;
      outcomes_checked++;
      if (pending_outcomes.size() == 0) begin
        flag_mismatch($sformatf("unrequested result: ok=%0b value=%h count=%0d",
                                ok, rd, cnt));
        return;
      end
      want = pending_outcomes.pop_front();
      if (ok !== want.ok)
        flag_mismatch($sformatf("ok: got %b, want %b", ok, want.ok));
      if (rd !== want.read_value)
        flag_mismatch($sformatf("read_value: got %h, want %h", rd, want.read_value));
      if (cnt !== want.count)
        flag_mismatch($sformatf("count: got %0d, want %0d", cnt, want.count));
    endtask
  endclass

  logic        clk;
  logic        rst = 1'b1;
  logic        cfg_wen = 1'b0;
  logic [5:0]  cfg_wdata = '0;
  logic        s_axis_tvalid = 1'b0;
  logic        s_axis_tready;
  logic [39:0] s_axis_tdata = '0;   // [5:0] position, [37:6] value, [39:38] zero
  logic [1:0]  s_axis_tuser = '0;   // [1:0] req_type
  logic        m_axis_tvalid;
  logic        m_axis_tready = 1'b0;
  logic [39:0] m_axis_tdata;        // [31:0] read_value, [37:32] count, [39:38] zero
  logic [0:0]  m_axis_tuser;        // [0] ok

  array_list_tracker tracker;

  // idling odds, in percent, for the current phase
  int send_idle_pct = 0;
  int recv_stall_pct = 0;
  // hold-off request from the stimulus thread and the cycles left in it
  bit hold_req = 1'b0;
  int hold_left = 0;

  array_list_insert_delete dut (
    .clk          (clk),
    .rst          (rst),
    .cfg_wen      (cfg_wen),
    .cfg_wdata    (cfg_wdata),
    .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready),
    .s_axis_tdata (s_axis_tdata),
    .s_axis_tuser (s_axis_tuser),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .m_axis_tdata (m_axis_tdata),
    .m_axis_tuser (m_axis_tuser)
  );

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  // Sample both channels at the rising edge. Check the result beat first:
  // the result is registered, so it always belongs to an earlier request.
  always @(posedge clk) begin
    if (!rst) begin
      if (m_axis_tvalid && m_axis_tready)
        tracker.check_outcome(m_axis_tuser[0], m_axis_tdata[31:0], m_axis_tdata[37:32]);
      if (s_axis_tvalid && s_axis_tready)
        tracker.apply_request(s_axis_tuser, s_axis_tdata[5:0], s_axis_tdata[37:6]);
    end
  end

  // Receiver: stall at random, or hold off for a long stretch on request.
  initial begin
    forever begin
      @(negedge clk);
      if (hold_left == 0 && hold_req) begin
        hold_left = HOLD_CYCLES;
        hold_req = 1'b0;
      end
      if (hold_left > 0) begin
        hold_left--;
        m_axis_tready <= 1'b0;
      end else begin
        m_axis_tready <= ($urandom_range(99) >= recv_stall_pct);
      end
    end
  end

  // Offer one request beat, idling first at random; return at the falling
  // edge after it is taken, with tvalid still high.
  task automatic send_request(input logic [1:0] kind,
                              input logic [alid_pkg::POS_W-1:0] pos,
                              input logic [alid_pkg::DATA_W-1:0] value);
    while ($urandom_range(99) < send_idle_pct) begin
      s_axis_tvalid <= 1'b0;
      @(negedge clk);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tuser  <= kind;
    s_axis_tdata  <= {2'b00, value, pos};
    do @(posedge clk); while (!s_axis_tready);
    @(negedge clk);
  endtask

  // Drop tvalid and wait for every outstanding result, plus a short margin.
  task automatic drain_list_ops();
    s_axis_tvalid <= 1'b0;
    while (tracker.pending_outcomes.size() != 0) @(negedge clk);
    repeat (3) @(negedge clk);
  endtask

  // Write the capacity register only once the block has gone quiet.
  task automatic write_capacity(input logic [alid_pkg::CAP_W-1:0] cap);
    drain_list_ops();
    cfg_wen   <= 1'b1;
    cfg_wdata <= cap;
    tracker.set_capacity(cap);
    @(negedge clk);
    cfg_wen <= 1'b0;
  endtask

  function automatic logic [alid_pkg::DATA_W-1:0] pick_value();
    case ($urandom_range(7))
      0: return 32'h7FFF_FFFF;
      1: return 32'h8000_0000;
      2: return 32'h0000_0000;
      3: return 32'hFFFF_FFFF;
      default: return $urandom;
    endcase
  endfunction

  // Mostly well-formed requests against the current length; a few beats
  // of noise with any kind and any position. grow tilts toward inserts.
  task automatic send_random(input bit grow);
    int n;
    int roll;
    logic [1:0] kind;
    logic [alid_pkg::POS_W-1:0] pos;
    n = tracker.fill;
    roll = $urandom_range(99);
    if (roll < 6) begin
      kind = 2'($urandom_range(3));
      pos  = alid_pkg::POS_W'($urandom_range(63));
    end else if (roll < (grow ? 62 : 24)) begin
      kind = alid_pkg::REQ_INSERT;
      pos  = alid_pkg::POS_W'($urandom_range(n) - 1);      // -1 .. fill-1
    end else if (roll < (grow ? 80 : 78)) begin
      kind = alid_pkg::REQ_DELETE;
      pos  = (n > 0) ? alid_pkg::POS_W'($urandom_range(n - 1)) : 6'd0;
    end else begin
      kind = alid_pkg::REQ_READ;
      pos  = (n > 0) ? alid_pkg::POS_W'($urandom_range(n - 1)) : 6'd0;
    end
    send_request(kind, pos, pick_value());
  endtask

  initial begin
    tracker = new();
    repeat (9) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    // Directed: empty list, both ends, rejected positions, unknown kind.
    send_request(alid_pkg::REQ_DELETE, 6'd0, 32'h0);            // delete from empty list
    send_request(alid_pkg::REQ_READ,   6'd0, 32'h0);            // read past the count
    send_request(alid_pkg::REQ_INSERT, 6'd0, 32'h1234_5678);    // insert leaving a gap
    send_request(alid_pkg::REQ_INSERT, alid_pkg::POS_FRONT, 32'h7FFF_FFFF);
    send_request(alid_pkg::REQ_INSERT, alid_pkg::POS_FRONT, 32'h8000_0000);
    send_request(alid_pkg::REQ_INSERT, 6'd1, 32'h0000_0000);    // append at the tail
    send_request(alid_pkg::REQ_INSERT, 6'd0, 32'hFFFF_FFFF);    // insert in the middle
    send_request(alid_pkg::REQ_INSERT, 6'b111110, 32'h5A5A_5A5A); // below front
    send_request(alid_pkg::REQ_INSERT, 6'b100000, 32'hA5A5_A5A5); // most negative position
    send_request(alid_pkg::REQ_READ,   6'd0, 32'h0);
    send_request(alid_pkg::REQ_READ,   6'd1, 32'h0);
    send_request(alid_pkg::REQ_READ,   6'd3, 32'h0);
    send_request(alid_pkg::REQ_READ,   6'd4, 32'h0);            // at the count
    send_request(alid_pkg::REQ_READ,   alid_pkg::POS_FRONT, 32'h0);
    send_request(alid_pkg::REQ_READ,   6'd31, 32'h0);
    send_request(REQ_UNKNOWN, 6'd0, 32'hDEAD_BEEF);
    send_request(alid_pkg::REQ_DELETE, 6'd3, 32'h0);            // drop the tail
    send_request(alid_pkg::REQ_DELETE, 6'd0, 32'h0);            // drop the head
    send_request(alid_pkg::REQ_DELETE, alid_pkg::POS_FRONT, 32'h0);
    send_request(alid_pkg::REQ_DELETE, 6'd31, 32'h0);
    send_request(alid_pkg::REQ_READ,   6'd1, 32'h0);

    // Capacity 1: the list already holds more entries, so both inserts are refused. Capacity 0 refuses all.
    write_capacity(6'd1);
    send_request(alid_pkg::REQ_INSERT, alid_pkg::POS_FRONT, 32'h0F0F_0F0F);
    send_request(alid_pkg::REQ_INSERT, alid_pkg::POS_FRONT, 32'hF0F0_F0F0);
    write_capacity(6'd0);
    send_request(alid_pkg::REQ_INSERT, alid_pkg::POS_FRONT, 32'h1111_1111);
    send_request(alid_pkg::REQ_DELETE, 6'd0, 32'h0);

    // Random phases: no idling, idle sender, stalling receiver, both.
    for (int phase = 0; phase < 4; phase++) begin
      case (phase)
        0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
        1: begin send_idle_pct = 74; recv_stall_pct = 0;  end
        2: begin send_idle_pct = 0;  recv_stall_pct = 74; end
        default: begin send_idle_pct = 13; recv_stall_pct = 13; end
      endcase
      if (phase == 0) begin
        // hold the receiver off and keep offering beats until the input stalls
        write_capacity(6'd32);
        hold_req = 1'b1;
        repeat (40) send_random(1'b1);
      end
      for (int blk = 0; blk < 6; blk++) begin
        case ((phase * 6 + blk) % 8)
          0: write_capacity(6'd32);
          1: write_capacity(6'd5);
          2: write_capacity(6'd1);
          3: write_capacity(6'd63);
          4: write_capacity(6'd0);
          5: write_capacity(6'd17);
          6: write_capacity(6'd2);
          default: write_capacity(6'd32);
        endcase
        repeat (75) send_random(blk % 3 != 2);
      end
    end

    // Wait out the last results, then watch for stray beats.
    drain_list_ops();
    repeat (8) @(negedge clk);
    if (tracker.pending_outcomes.size() != 0)
      tracker.flag_mismatch($sformatf("%0d results never arrived",
                                      tracker.pending_outcomes.size()));

    $display("Requests: %0d reads (%0d hit), %0d inserts (%0d placed),",
             tracker.seen_by_kind[alid_pkg::REQ_READ],
             tracker.done_by_kind[alid_pkg::REQ_READ],
             tracker.seen_by_kind[alid_pkg::REQ_INSERT],
             tracker.done_by_kind[alid_pkg::REQ_INSERT]);
    $display("  %0d deletes (%0d removed), %0d of unknown kind; %0d results checked",
             tracker.seen_by_kind[alid_pkg::REQ_DELETE],
             tracker.done_by_kind[alid_pkg::REQ_DELETE],
             tracker.seen_by_kind[REQ_UNKNOWN], tracker.outcomes_checked);
    $display("Longest list %0d entries; %0d inserts refused as full",
             tracker.peak_fill, tracker.full_rejects);
    if (tracker.mismatches == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

  // Watchdog: far beyond the slowest legal run.
  initial begin
    #400000;
    $display("Timed out with %0d results outstanding", tracker.pending_outcomes.size());
    $display("Mismatches found");
    $finish;
  end

endmodule
